>>> hw/rtl/gsf_pkg.sv
package gsf_pkg;

    localparam int FRAME_LEN    = 19;
    localparam int CRC_FIRST    = 15;
    localparam int IDX_W        = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR  = CFG_IDX_W'(1);

    localparam logic [15:0] HOLD_RESET   = 16'd100;
    localparam logic [7:0]  THRESH_RESET = 8'd32;
    localparam logic [7:0]  LEN_BYTE     = ~8'(FRAME_LEN);
    localparam logic [7:0]  MSG_TYPE     = 8'h90;
    localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [3:0]  HAT_NEUTRAL  = 4'd8;

    // one classified snapshot, everything the back end needs for a frame
    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] hold;
        logic [7:0]  btn_lo;
        logic [7:0]  btn_hi;
        logic [3:0]  hat;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } t_gsf_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_gsf_qstat;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [3:0] hat_code(input logic [3:0] dir);
        logic up, dn, rt, lf;
        up = dir[0] & ~dir[1];
        dn = dir[1] & ~dir[0];
        lf = dir[2] & ~dir[3];
        rt = dir[3] & ~dir[2];
        if (up) return rt ? 4'd1 : (lf ? 4'd7 : 4'd0);
        if (dn) return rt ? 4'd3 : (lf ? 4'd5 : 4'd4);
        if (rt) return 4'd2;
        if (lf) return 4'd6;
        return HAT_NEUTRAL;
    endfunction

    // high byte of value + 32768
    function automatic logic [7:0] stick_byte(input logic signed [15:0] v);
        return v[15:8] ^ 8'h80;
    endfunction

endpackage

>>> hw/rtl/gsf_front.sv
module gsf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [15:0]                    i_buttons,
    input  logic [7:0]                     i_left_trigger,
    input  logic [7:0]                     i_right_trigger,
    input  logic signed [15:0]             i_left_stick_x,
    input  logic signed [15:0]             i_left_stick_y,
    input  logic signed [15:0]             i_right_stick_x,
    input  logic signed [15:0]             i_right_stick_y,
    input  logic                           i_cfg_valid,
    input  logic [gsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  gsf_pkg::t_gsf_qstat            i_qstat,
    output logic                           o_wr_en,
    output gsf_pkg::t_gsf_desc             o_desc
);

    logic [31:0] r_seq;
    logic [15:0] r_hold;
    logic [7:0]  r_thresh;

    assign o_wr_en = i_push & ~i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_hold   <= gsf_pkg::HOLD_RESET;
            r_thresh <= gsf_pkg::THRESH_RESET;
        end else begin
            if (o_wr_en) begin
                r_seq <= r_seq + 32'd1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gsf_pkg::CFG_HOLD_TIME: r_hold   <= i_cfg_data[15:0];
                    gsf_pkg::CFG_TRIG_THR:  r_thresh <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_desc.seq    = r_seq;
        o_desc.hold   = r_hold;
        o_desc.btn_lo = {i_right_trigger >= r_thresh, i_left_trigger >= r_thresh,
                         i_buttons[9], i_buttons[8], i_buttons[6], i_buttons[5],
                         i_buttons[4], i_buttons[7]};
        o_desc.btn_hi = {2'b00, i_buttons[15:10]};
        o_desc.hat    = gsf_pkg::hat_code(i_buttons[3:0]);
        o_desc.lx     = gsf_pkg::stick_byte(i_left_stick_x);
        o_desc.ly     = gsf_pkg::stick_byte(i_left_stick_y);
        o_desc.rx     = gsf_pkg::stick_byte(i_right_stick_x);
        o_desc.ry     = gsf_pkg::stick_byte(i_right_stick_y);
    end

endmodule

>>> hw/rtl/gsf_queue.sv
module gsf_queue #(
    parameter int DEPTH = gsf_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  gsf_pkg::t_gsf_desc  i_wr_data,
    input  logic                i_rd_en,
    output gsf_pkg::t_gsf_desc  o_rd_data,
    output gsf_pkg::t_gsf_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsf_pkg::t_gsf_desc r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_wr         = i_wr_en & ~o_stat.full;
    assign w_rd         = i_rd_en & ~o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/gsf_back.sv
module gsf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsf_pkg::t_gsf_desc  i_desc,
    input  gsf_pkg::t_gsf_qstat i_qstat,
    output logic                o_rd_en,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_frame_byte,
    output logic                o_frame_end
);

    logic [gsf_pkg::IDX_W-1:0] r_idx;
    logic [31:0]               r_crc;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_end;

    logic                      w_adv;
    logic                      w_last;
    logic [7:0]                w_byte;
    logic [31:0]               w_crc_in;
    logic [31:0]               w_crc_out;

    assign w_adv   = ~i_qstat.empty & (~r_out_valid | i_pop);
    assign w_last  = (r_idx == gsf_pkg::IDX_W'(gsf_pkg::FRAME_LEN - 1));
    assign o_rd_en = w_adv & w_last;

    assign o_empty      = ~r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

    always_comb begin
        w_crc_out = ~r_crc;
        case (r_idx)
            5'd0:    w_byte = gsf_pkg::LEN_BYTE;
            5'd1:    w_byte = gsf_pkg::MSG_TYPE;
            5'd2:    w_byte = i_desc.seq[7:0];
            5'd3:    w_byte = i_desc.seq[15:8];
            5'd4:    w_byte = i_desc.seq[23:16];
            5'd5:    w_byte = i_desc.seq[31:24];
            5'd6:    w_byte = i_desc.hold[7:0];
            5'd7:    w_byte = i_desc.hold[15:8];
            5'd8:    w_byte = i_desc.btn_lo;
            5'd9:    w_byte = i_desc.btn_hi;
            5'd10:   w_byte = {4'd0, i_desc.hat};
            5'd11:   w_byte = i_desc.lx;
            5'd12:   w_byte = i_desc.ly;
            5'd13:   w_byte = i_desc.rx;
            5'd14:   w_byte = i_desc.ry;
            5'd15:   w_byte = w_crc_out[7:0];
            5'd16:   w_byte = w_crc_out[15:8];
            5'd17:   w_byte = w_crc_out[23:16];
            5'd18:   w_byte = w_crc_out[31:24];
            default: w_byte = '0;
        endcase
        w_crc_in = (r_idx == '0) ? gsf_pkg::CRC_INIT : r_crc;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_end  <= w_last;
            if (r_idx < gsf_pkg::IDX_W'(gsf_pkg::CRC_FIRST)) begin
                r_crc <= gsf_pkg::crc32c_byte(w_crc_in, w_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_last ? '0 : r_idx + gsf_pkg::IDX_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/gamepad_state_crc32c_framer.sv
// Gamepad snapshot framer: one snapshot in, one 19-byte CRC32C frame out.
// Input side is a queue: drive the snapshot fields with push; the snapshot
// is taken on an edge where push is high and full is low.
// Output side is a queue too: while empty is low, o_frame_byte holds the
// next frame byte and o_frame_end flags the last (top CRC byte); pop takes it.
// Registers (hold time, trigger threshold) are written over the cfg channel,
// which is always ready; write them only while no frame is in flight.
// Path: the first byte of a frame passes from the descriptor queue into the
// byte-wide output register fed by the frame sequencer. Throughput: one byte
// per cycle while the receiver pops every byte and descriptors are queued.
// A descriptor queue of QUEUE_DEPTH entries sits between the classifier and
// the sequencer, so further snapshots are taken while a frame drains.
// When the receiver stalls, the output byte holds, the sequencer waits and
// full rises once the queue fills.
// Reset: queues empty, sequence number 0, hold time 100 ms, threshold 32.
module gamepad_state_crc32c_framer #(
    parameter int QUEUE_DEPTH = gsf_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [15:0]                    i_buttons,
    input  logic [7:0]                     i_left_trigger,
    input  logic [7:0]                     i_right_trigger,
    input  logic signed [15:0]             i_left_stick_x,
    input  logic signed [15:0]             i_left_stick_y,
    input  logic signed [15:0]             i_right_stick_x,
    input  logic signed [15:0]             i_right_stick_y,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_frame_byte,
    output logic                           o_frame_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gsf_pkg::t_gsf_desc  w_wr_desc;
    gsf_pkg::t_gsf_desc  w_rd_desc;
    gsf_pkg::t_gsf_qstat w_qstat;
    logic                w_wr_en;
    logic                w_rd_en;

    assign o_cfg_ready = 1'b1;
    assign full        = w_qstat.full;

    gsf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_buttons       (i_buttons),
        .i_left_trigger  (i_left_trigger),
        .i_right_trigger (i_right_trigger),
        .i_left_stick_x  (i_left_stick_x),
        .i_left_stick_y  (i_left_stick_y),
        .i_right_stick_x (i_right_stick_x),
        .i_right_stick_y (i_right_stick_y),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_qstat         (w_qstat),
        .o_wr_en         (w_wr_en),
        .o_desc          (w_wr_desc)
    );

    gsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_wr_desc),
        .i_rd_en   (w_rd_en),
        .o_rd_data (w_rd_desc),
        .o_stat    (w_qstat)
    );

    gsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_rd_desc),
        .i_qstat      (w_qstat),
        .o_rd_en      (w_rd_en),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

    // each taken snapshot bumps the sequence number by exactly one
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && i_rst_n) |=> (w_wr_desc.seq == $past(w_wr_desc.seq) + 32'd1))
        else $error("sequence number did not step on snapshot");

    // a frame only finishes while a descriptor is held
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> !w_qstat.empty)
        else $error("frame finished with no descriptor queued");

    // after the sequencer issues the top CRC byte, the output holds a byte with the end of frame flag
    a_end_then_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> (!empty && o_frame_end))
        else $error("frame end not flagged on last byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule
